// ----- rtl/rcle_pkg.sv -----
// shared constants, types and register codes for the centered-lift base extension core
// no dependencies

package rcle_pkg;

   localparam int MOD_BITS        = 62;
   localparam int TARGET_REGS     = 4;
   localparam int MAX_TARGETS_DEF = 4;
   localparam int WORD_BITS_DEF   = 64;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_ADDR_W      = 6;
   localparam int REG_IDX_W       = 3;
   localparam int COUNT_W         = 3;
   localparam int TIDX_W          = 2;
   localparam int RSP_DATA_W      = 64;

   typedef logic [MOD_BITS-1:0]  mod_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [TIDX_W-1:0]    tidx_type;
   typedef logic [REG_IDX_W-1:0] reg_idx_type;

   localparam reg_idx_type REG_OLD_MODULUS  = 3'd0;
   localparam reg_idx_type REG_TARGET_COUNT = 3'd1;
   localparam reg_idx_type REG_TARGET_MOD_0 = 3'd2;
   localparam reg_idx_type REG_TARGET_MOD_1 = 3'd3;
   localparam reg_idx_type REG_TARGET_MOD_2 = 3'd4;
   localparam reg_idx_type REG_TARGET_MOD_3 = 3'd5;

endpackage

// ----- rtl/rns_centered_lift_extend_core.sv -----
// top level: csr bank, coefficient reduction chain, centering stage, lift chain, result buffer
// depends on rcle_pkg, rcle_cell, rcle_out_buf
//
//  channel | direction | beat contents
//  req     | in        | tdata: coeff
//  rsp     | out       | tdata: residue; tuser: target_index; tlast: last
//  csr     | apb       | 64-bit registers at 8*i, writes and reads, pready always high
//
// accepts one coefficient per cycle while the result buffer has space; results leave at one
// per cycle while rsp_tready is high: one beat per target (1 to 4), set by the serializer
// the path runs reduction cells, centering, lift cells, result buffer; one bit step per cell
// reset clears the csr bank to its defaults and empties the pipeline; no clearing pass
// when the two-entry result buffer is full the whole cell chain holds and req_tready drops

module rns_centered_lift_extend_core #(
   parameter int MAX_TARGETS = rcle_pkg::MAX_TARGETS_DEF,
   parameter int WORD_BITS   = rcle_pkg::WORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((WORD_BITS+7)/8)*8-1:0]        req_tdata,   // coeff
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rcle_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // residue, zero pad
   output logic [rcle_pkg::TIDX_W-1:0]           rsp_tuser,   // target_index
   output logic                                  rsp_tlast,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rcle_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [rcle_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [rcle_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import rcle_pkg::*;

   // csr bank
   mod_type     old_mod_ff;
   count_type   tcount_ff;
   mod_type     tmod_ff [TARGET_REGS];
   reg_idx_type csr_idx;
   logic        csr_write;
   tidx_type    last_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         old_mod_ff <= MOD_BITS'(2);
         tcount_ff  <= COUNT_W'(1);
         for (int k = 0; k < TARGET_REGS; k++) begin
            tmod_ff[k] <= MOD_BITS'(2);
         end
      end else if (csr_write) begin
         case (csr_idx)
            REG_OLD_MODULUS:  old_mod_ff <= csr_pwdata[MOD_BITS-1:0];
            REG_TARGET_COUNT: tcount_ff  <= csr_pwdata[COUNT_W-1:0];
            REG_TARGET_MOD_0: tmod_ff[0] <= csr_pwdata[MOD_BITS-1:0];
            REG_TARGET_MOD_1: tmod_ff[1] <= csr_pwdata[MOD_BITS-1:0];
            REG_TARGET_MOD_2: tmod_ff[2] <= csr_pwdata[MOD_BITS-1:0];
            REG_TARGET_MOD_3: tmod_ff[3] <= csr_pwdata[MOD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_OLD_MODULUS:  csr_prdata = CSR_DATA_W'(old_mod_ff);
         REG_TARGET_COUNT: csr_prdata = CSR_DATA_W'(tcount_ff);
         REG_TARGET_MOD_0: csr_prdata = CSR_DATA_W'(tmod_ff[0]);
         REG_TARGET_MOD_1: csr_prdata = CSR_DATA_W'(tmod_ff[1]);
         REG_TARGET_MOD_2: csr_prdata = CSR_DATA_W'(tmod_ff[2]);
         REG_TARGET_MOD_3: csr_prdata = CSR_DATA_W'(tmod_ff[3]);
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (tcount_ff == '0) begin
         last_idx = '0;
      end else if (tcount_ff > COUNT_W'(MAX_TARGETS)) begin
         last_idx = TIDX_W'(MAX_TARGETS - 1);
      end else begin
         last_idx = TIDX_W'(tcount_ff - COUNT_W'(1));
      end
   end

   // coefficient mod old modulus
   logic                 advance;
   logic                 q_valid [WORD_BITS+1];
   logic [WORD_BITS-1:0] q_div   [WORD_BITS+1];
   mod_type              q_rem   [WORD_BITS+1][1];
   mod_type              q_moduli [1];

   assign req_tready  = advance;
   assign q_moduli[0] = old_mod_ff;
   assign q_valid[0]  = req_tvalid;
   assign q_div[0]    = req_tdata[WORD_BITS-1:0];
   assign q_rem[0][0] = '0;

   for (genvar i = 0; i < WORD_BITS; i++) begin : g_qchain
      rcle_cell #(
         .LANES (1),
         .DIV_W (WORD_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .moduli    (q_moduli),
         .in_valid  (q_valid[i]),
         .in_div    (q_div[i]),
         .in_rem    (q_rem[i]),
         .out_valid (q_valid[i+1]),
         .out_div   (q_div[i+1]),
         .out_rem   (q_rem[i+1])
      );
   end

   // centering
   logic    cen_valid_ff;
   mod_type cen_div_ff, cen_div_in;
   logic    cen_neg_ff, cen_neg_in;

   always_comb begin
      mod_type           c;
      logic [MOD_BITS:0] twice;
      logic              q_ok;
      q_ok  = (old_mod_ff >= MOD_BITS'(2));
      c     = q_ok ? q_rem[WORD_BITS][0] : '0;
      twice = {c, 1'b0};
      cen_neg_in = q_ok && (twice >= {1'b0, old_mod_ff});
      cen_div_in = cen_neg_in ? (old_mod_ff - c) : c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cen_valid_ff <= 1'b0;
      end else if (advance) begin
         cen_valid_ff <= q_valid[WORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cen_div_ff <= cen_div_in;
         cen_neg_ff <= cen_neg_in;
      end
   end

   // lift to every target modulus
   logic                l_valid [MOD_BITS+1];
   mod_type             l_div   [MOD_BITS+1];
   mod_type             l_rem   [MOD_BITS+1][MAX_TARGETS];
   mod_type             l_moduli [MAX_TARGETS];
   logic [MOD_BITS-1:0] neg_pipe_ff;

   assign l_valid[0] = cen_valid_ff;
   assign l_div[0]   = cen_div_ff;

   for (genvar k = 0; k < MAX_TARGETS; k++) begin : g_lanes
      assign l_moduli[k] = tmod_ff[k];
      assign l_rem[0][k] = '0;
   end

   for (genvar i = 0; i < MOD_BITS; i++) begin : g_lchain
      rcle_cell #(
         .LANES (MAX_TARGETS),
         .DIV_W (MOD_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .moduli    (l_moduli),
         .in_valid  (l_valid[i]),
         .in_div    (l_div[i]),
         .in_rem    (l_rem[i]),
         .out_valid (l_valid[i+1]),
         .out_div   (l_div[i+1]),
         .out_rem   (l_rem[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_pipe_ff <= {neg_pipe_ff[MOD_BITS-2:0], cen_neg_ff};
      end
   end

   // result buffer
   mod_type  out_residue;
   tidx_type out_tidx;

   rcle_out_buf #(
      .MAX_TARGETS (MAX_TARGETS)
   ) u_out (
      .clock       (clock),
      .reset       (reset),
      .wr_valid    (l_valid[MOD_BITS] && advance),
      .wr_neg      (neg_pipe_ff[MOD_BITS-1]),
      .wr_rem      (l_rem[MOD_BITS]),
      .target_mod  (tmod_ff),
      .last_idx    (last_idx),
      .space       (advance),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_residue (out_residue),
      .out_tidx    (out_tidx),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'(out_residue);
   assign rsp_tuser = out_tidx;

endmodule

// ----- rtl/rcle_cell.sv -----
// one restoring remainder step per lane: shifts in the dividend msb and subtracts the modulus
// depends on rcle_pkg

module rcle_cell #(
   parameter int LANES = 1,
   parameter int DIV_W = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  rcle_pkg::mod_type     moduli [LANES],
   input  logic                  in_valid,
   input  logic [DIV_W-1:0]      in_div,
   input  rcle_pkg::mod_type     in_rem [LANES],
   output logic                  out_valid,
   output logic [DIV_W-1:0]      out_div,
   output rcle_pkg::mod_type     out_rem [LANES]
);
   import rcle_pkg::*;

   logic              valid_ff, valid_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   mod_type           rem_ff [LANES];
   mod_type           rem_in [LANES];

   always_comb begin
      logic [MOD_BITS:0] shifted;
      logic [MOD_BITS:0] modx;
      logic [MOD_BITS:0] diff;
      valid_in = in_valid;
      div_in   = in_div << 1;
      for (int l = 0; l < LANES; l++) begin
         shifted = {in_rem[l], in_div[DIV_W-1]};
         modx    = {1'b0, moduli[l]};
         diff    = shifted - modx;
         if (shifted >= modx) begin
            rem_in[l] = diff[MOD_BITS-1:0];
         end else begin
            rem_in[l] = shifted[MOD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff <= div_in;
         rem_ff <= rem_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_rem   = rem_ff;

endmodule

// ----- rtl/rcle_out_buf.sv -----
// two-entry result buffer with final sign fix-up and per-target serializer
// depends on rcle_pkg

module rcle_out_buf #(
   parameter int MAX_TARGETS = rcle_pkg::MAX_TARGETS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   input  logic                  wr_neg,
   input  rcle_pkg::mod_type     wr_rem [MAX_TARGETS],
   input  rcle_pkg::mod_type     target_mod [rcle_pkg::TARGET_REGS],
   input  rcle_pkg::tidx_type    last_idx,
   output logic                  space,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rcle_pkg::mod_type     out_residue,
   output rcle_pkg::tidx_type    out_tidx,
   output logic                  out_last
);
   import rcle_pkg::*;

   localparam int DEPTH = 2;

   mod_type   lifted [TARGET_REGS];
   mod_type   slot_ff [DEPTH][TARGET_REGS];
   logic      head_ff, head_in;
   logic      tail_ff, tail_in;
   logic [1:0] cnt_ff, cnt_in;
   tidx_type  idx_ff, idx_in;
   logic      pop_beat, pop_item;

   for (genvar k = 0; k < TARGET_REGS; k++) begin : g_lift
      if (k < MAX_TARGETS) begin : g_used
         always_comb begin
            if (target_mod[k] < MOD_BITS'(2)) begin
               lifted[k] = '0;
            end else if (wr_neg && (wr_rem[k] != '0)) begin
               lifted[k] = target_mod[k] - wr_rem[k];
            end else begin
               lifted[k] = wr_rem[k];
            end
         end
      end else begin : g_unused
         assign lifted[k] = '0;
      end
   end

   assign out_valid   = (cnt_ff != 2'd0);
   assign out_residue = slot_ff[head_ff][idx_ff];
   assign out_tidx    = idx_ff;
   assign out_last    = (idx_ff == last_idx);
   assign space       = (cnt_ff != 2'(DEPTH));
   assign pop_beat    = out_valid && out_ready;
   assign pop_item    = pop_beat && out_last;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      if (pop_beat) begin
         if (pop_item) begin
            idx_in  = '0;
            head_in = ~head_ff;
         end else begin
            idx_in = idx_ff + tidx_type'(1);
         end
      end
      if (wr_valid) begin
         tail_in = ~tail_ff;
      end
      if (wr_valid && !pop_item) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!wr_valid && pop_item) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         tail_ff <= 1'b0;
         cnt_ff  <= '0;
         idx_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         slot_ff[tail_ff] <= lifted;
      end
   end

endmodule

// ----- tb/rns_centered_lift_extend_core_test.sv -----
// self-checking testbench for rns_centered_lift_extend_core: centered lift of one coefficient
// into up to four new moduli, compared beat by beat with an in-bench residue predictor
// depends on rcle_pkg and the rns_centered_lift_extend_core rtl

module rns_centered_lift_extend_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rcle_pkg::*;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 160;
   localparam int          IDLE_PCT     = 37;
   localparam int          REG_COUNT    = 6;
   localparam int          DIR_ROWS     = 31;
   localparam reg_idx_type UNMAPPED_REG = 3'd6;
   localparam logic [63:0] ALL_ONES     = '1;
   localparam logic [63:0] MOD_MAX      = 64'h3FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      mod_type  residue;
      tidx_type index;
      logic     last;
   } residue_beat_type;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      reg_idx_type  idx;
      logic [63:0]  value;
      logic         known;
      mod_type      known_res;
   } stim_row_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [63:0]             req_tdata   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [TIDX_W-1:0]       rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   mod_type          q_reg;
   count_type        count_reg;
   mod_type          tmod_reg [TARGET_REGS];
   residue_beat_type pending_residues [$];
   logic             known_now     = 1'b0;
   mod_type          known_res_now = '0;
   bit               calm          = 1'b0;
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   stim_row_type     directed_rows [DIR_ROWS];

   rns_centered_lift_extend_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // coeff
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // residue, zero pad
      .rsp_tuser   (rsp_tuser),    // target_index
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic void lift_residues(input logic [63:0] coeff, input logic known,
                                         input mod_type known_res);
      logic [63:0]      q, c, mag, p, r;
      logic             neg;
      int               n;
      residue_beat_type b;
      q = 64'(q_reg);
      if (q < 2) c = '0;
      else c = coeff % q;
      neg = (q >= 2) && ((c << 1) >= q);
      mag = neg ? q - c : '0;
      if (count_reg == 0) n = 1;
      else if (count_reg > MAX_TARGETS_DEF) n = MAX_TARGETS_DEF;
      else n = int'(count_reg);
      for (int k = 0; k < n; k++) begin
         p = 64'(tmod_reg[k]);
         if (p < 2) begin
            r = '0;
         end else if (!neg) begin
            r = c % p;
         end else begin
            r = mag % p;
            if (r != 0) r = p - r;
         end
         b.residue = known ? known_res : r[MOD_BITS-1:0];
         b.index   = tidx_type'(k);
         b.last    = (k == n - 1);
         pending_residues.push_back(b);
      end
   endfunction

   function automatic logic [63:0] pick_modulus(input bit allow_tiny);
      case ($urandom_range(9))
         0:       return allow_tiny ? 64'($urandom_range(3)) : 64'($urandom_range(2, 3));
         1, 2:    return 64'($urandom_range(2, 1000));
         3:       return MOD_MAX;
         4:       return 64'd1 << $urandom_range(1, 61);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] pick_coeff();
      logic [63:0] q;
      q = 64'(q_reg);
      case ($urandom_range(7))
         0:       return ALL_ONES - 64'($urandom_range(3));
         1:       return 64'($urandom_range(20));
         2:       return (q >> 1) - 64'd1 + 64'($urandom_range(2));
         3:       return q * 64'($urandom_range(4)) + 64'($urandom_range(3)) - 64'd1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic csr_write(input reg_idx_type idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_OLD_MODULUS:  q_reg = value[MOD_BITS-1:0];
         REG_TARGET_COUNT: count_reg = value[COUNT_W-1:0];
         REG_TARGET_MOD_0, REG_TARGET_MOD_1, REG_TARGET_MOD_2, REG_TARGET_MOD_3: begin
            tmod_reg[tidx_type'(idx - REG_TARGET_MOD_0)] = value[MOD_BITS-1:0];
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_residues.size() != 0) @(posedge clock);
   endtask

   task automatic send_coeff(input logic [63:0] value, input logic known,
                             input mod_type known_res);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tdata     <= value;
      known_now     <= known;
      known_res_now <= known_res;
      do @(posedge clock); while (!req_tready);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result checking and expectation capture
   always @(posedge clock) begin
      residue_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_residues.size() == 0) begin
            $error("unexpected result beat: residue %0h index %0d last %0b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_residues.pop_front();
            if (rsp_tdata !== RSP_DATA_W'(want.residue)) begin
               $error("residue: expected %0h, got %0h", want.residue, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.index) begin
               $error("target_index: expected %0d, got %0d", want.index, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) lift_residues(req_tdata, known_now, known_res_now);
   end

   initial begin
      int          hold;
      int          start;
      reg_idx_type idx;
      q_reg     = 62'd2;
      count_reg = 3'd1;
      foreach (tmod_reg[i]) tmod_reg[i] = 62'd2;
      directed_rows = '{
         '{ROW_ITEM, '0, 64'd0, 1'b1, 62'd0},
         '{ROW_ITEM, '0, 64'd1, 1'b1, 62'd1},
         '{ROW_ITEM, '0, ALL_ONES, 1'b1, 62'd1},
         '{ROW_CFG, REG_OLD_MODULUS, 64'd7, 1'b0, 62'd0},
         '{ROW_CFG, REG_TARGET_COUNT, 64'd4, 1'b0, 62'd0},
         '{ROW_CFG, REG_TARGET_MOD_0, 64'd5, 1'b0, 62'd0},
         '{ROW_CFG, REG_TARGET_MOD_1, 64'd3, 1'b0, 62'd0},
         '{ROW_CFG, REG_TARGET_MOD_2, MOD_MAX, 1'b0, 62'd0},
         '{ROW_CFG, REG_TARGET_MOD_3, 64'd1, 1'b0, 62'd0},
         '{ROW_ITEM, '0, 64'd3, 1'b0, 62'd0},
         '{ROW_ITEM, '0, 64'd4, 1'b0, 62'd0},
         '{ROW_ITEM, '0, 64'd7, 1'b1, 62'd0},
         '{ROW_ITEM, '0, ALL_ONES, 1'b0, 62'd0},
         '{ROW_CFG, REG_OLD_MODULUS, ALL_ONES, 1'b0, 62'd0},
         '{ROW_CFG, REG_TARGET_COUNT, 64'd0, 1'b0, 62'd0},
         '{ROW_ITEM, '0, 64'd0, 1'b1, 62'd0},
         '{ROW_ITEM, '0, 64'h3FFF_FFFF_FFFF_FFFD, 1'b0, 62'd0},
         '{ROW_ITEM, '0, ALL_ONES, 1'b0, 62'd0},
         '{ROW_ITEM, '0, 64'h8000_0000_0000_0000, 1'b0, 62'd0},
         '{ROW_ITEM, '0, 64'h1FFF_FFFF_FFFF_FFFF, 1'b0, 62'd0},
         '{ROW_CFG, REG_TARGET_COUNT, 64'd7, 1'b0, 62'd0},
         '{ROW_CFG, REG_OLD_MODULUS, 64'd0, 1'b0, 62'd0},
         '{ROW_ITEM, '0, 64'd12345, 1'b1, 62'd0},
         '{ROW_CFG, REG_OLD_MODULUS, 64'd1, 1'b0, 62'd0},
         '{ROW_ITEM, '0, ALL_ONES, 1'b1, 62'd0},
         '{ROW_CFG, REG_OLD_MODULUS, 64'd10, 1'b0, 62'd0},
         '{ROW_CFG, REG_TARGET_MOD_0, 64'd0, 1'b0, 62'd0},
         '{ROW_CFG, UNMAPPED_REG, 64'h1234_5678_9ABC_DEF0, 1'b0, 62'd0},
         '{ROW_ITEM, '0, 64'd5, 1'b0, 62'd0},
         '{ROW_ITEM, '0, 64'd4, 1'b0, 62'd0},
         '{ROW_ITEM, '0, 64'd6, 1'b0, 62'd0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CFG) begin
            wait_drained();
            csr_write(directed_rows[r].idx, directed_rows[r].value);
         end else begin
            send_coeff(directed_rows[r].value, directed_rows[r].known,
                       directed_rows[r].known_res);
         end
      end

      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         calm  = (ph == 3);
         start = $urandom_range(REG_COUNT - 1);
         for (int j = 0; j < REG_COUNT; j++) begin
            idx = reg_idx_type'((start + j) % REG_COUNT);
            if (idx == REG_TARGET_COUNT) csr_write(idx, {$urandom, $urandom});
            else csr_write(idx, pick_modulus(ph >= 6));
         end
         if ($urandom_range(3) == 0) begin
            csr_write(UNMAPPED_REG + reg_idx_type'($urandom_range(1)), {$urandom, $urandom});
         end
         hold = $urandom_range(10, 55);
         for (int i = 0; i < 65; i++) begin
            if (i == hold) wait_drained();
            send_coeff(pick_coeff(), 1'b0, '0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/rcle_pkg.sv
rtl/rcle_cell.sv
rtl/rcle_out_buf.sv
rtl/rns_centered_lift_extend_core.sv
tb/rns_centered_lift_extend_core_test.sv
